// ===== rtl/core/slope_matching_period_detector_defines.svh =====
// Assertion helpers for the period detector checker.
// Each expects clk and rst_n in scope.
`ifndef SLOPE_MATCHING_PERIOD_DETECTOR_DEFINES_SVH
`define SLOPE_MATCHING_PERIOD_DETECTOR_DEFINES_SVH

// same-cycle implication
`define SMPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/smpd_pkg.sv =====
package smpd_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int TIME_W        = 16;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int SAMPLE_W      = 8;
  localparam int SLOPE_W       = 8;
  localparam int TTOL_W        = 16;
  localparam int MISS_W        = 4;
  localparam int PERIOD_W      = 20;
  localparam int SUM_W         = (TIME_W + IDX_W > PERIOD_W) ? (TIME_W + IDX_W) : PERIOD_W;

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIDPOINT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_TOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TOL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT = 2'd3;

  localparam logic [SAMPLE_W-1:0] MIDPOINT_RST   = 8'd127;
  localparam logic [SLOPE_W-1:0]  SLOPE_TOL_RST  = 8'd3;
  localparam logic [TTOL_W-1:0]   TIME_TOL_RST   = 16'd10;
  localparam logic [MISS_W-1:0]   MISS_LIMIT_RST = 4'd9;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted beat
    logic eval;      // run the crossing / history update
    logic sum_rd;    // read one stored interval
    logic sum_add;   // accumulate it
    logic out_load;  // load the result register
  } smpd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // event matched entry 0
    logic more;      // intervals beyond entry 0 to sum
    logic last;      // current read is the final interval
  } smpd_stat_t;

endpackage

// ===== rtl/core/smpd_ram.sv =====
module smpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/smpd_ctrl.sv =====
module smpd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output smpd_pkg::smpd_cmd_t cmd,
  input  smpd_pkg::smpd_stat_t stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.hit) begin
          state_nxt = stat.more ? S_RD : S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.sum_rd = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.sum_add = 1'b1;
        state_nxt   = stat.last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/smpd_dpath.sv =====
module smpd_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [smpd_pkg::SAMPLE_W-1:0]        in_sample,
  input  logic                                 in_block_start,
  input  logic                                 cfg_we,
  input  logic [smpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smpd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  smpd_pkg::smpd_cmd_t                  cmd,
  output smpd_pkg::smpd_stat_t                 stat,
  output logic [smpd_pkg::PERIOD_W-1:0]        out_period
);

  localparam int SAMPLE_W = smpd_pkg::SAMPLE_W;
  localparam int SLOPE_W  = smpd_pkg::SLOPE_W;
  localparam int TIME_W   = smpd_pkg::TIME_W;
  localparam int IDX_W    = smpd_pkg::IDX_W;
  localparam int MISS_W   = smpd_pkg::MISS_W;
  localparam int SUM_W    = smpd_pkg::SUM_W;
  localparam int PERIOD_W = smpd_pkg::PERIOD_W;
  localparam int DEPTH    = smpd_pkg::HISTORY_DEPTH;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  function automatic logic [SLOPE_W-1:0] slope_diff(logic [SLOPE_W-1:0] a,
                                                    logic [SLOPE_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [TIME_W-1:0] time_diff(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // configuration
  logic [SAMPLE_W-1:0]           mid_r;
  logic [SLOPE_W-1:0]            stol_r;
  logic [smpd_pkg::TTOL_W-1:0]   ttol_r;
  logic [MISS_W-1:0]             mlim_r;

  // detector state
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                pvalid_r;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]    entry_r, entry_nxt;
  logic [SLOPE_W-1:0]  max_r, max_nxt;
  logic [MISS_W-1:0]   miss_r, miss_nxt;

  // payload
  logic [SAMPLE_W-1:0] cur_r;
  logic                blk_r;
  logic [TIME_W-1:0]   time0_r;
  logic [SLOPE_W-1:0]  slope0_r;
  logic [SUM_W-1:0]    acc_r;
  logic [IDX_W-1:0]    k_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TIME_W-1:0]   ram_rdata;

  // evaluation
  logic                pvalid_e;
  logic [SAMPLE_W-1:0] prev_e;
  logic [TIME_W-1:0]   elapsed_e;
  logic [IDX_W-1:0]    entry_e;
  logic [SLOPE_W-1:0]  max_e;
  logic [MISS_W-1:0]   miss_e;
  logic [IDX_W-1:0]    idx;
  logic [SLOPE_W-1:0]  slope;
  logic                crossing;
  logic                slope_near;
  logic                record;
  logic                rec_first;
  logic                hit;
  logic [MISS_W:0]     miss_inc;
  logic [TIME_W-1:0]   elapsed_n;

  always_comb begin
    // block_start clears the detector before the beat is used
    pvalid_e  = blk_r ? 1'b0 : pvalid_r;
    prev_e    = blk_r ? '0 : prev_r;
    elapsed_e = blk_r ? '0 : elapsed_r;
    entry_e   = blk_r ? '0 : entry_r;
    max_e     = blk_r ? '0 : max_r;
    miss_e    = blk_r ? '0 : miss_r;

    idx        = ({1'b0, entry_e} >= (IDX_W+1)'(DEPTH)) ? '0 : entry_e;
    slope      = cur_r - prev_e;
    crossing   = pvalid_e && (prev_e < mid_r) && (cur_r >= mid_r);
    slope_near = slope_diff(slope, max_e) < stol_r;
    record     = crossing && slope_near;
    rec_first  = record && (idx == '0);
    hit        = record && (idx != '0)
              && (32'(time_diff(time0_r, elapsed_e)) < 32'(ttol_r))
              && (slope_diff(slope0_r, slope) < stol_r);
    miss_inc   = {1'b0, miss_e} + (MISS_W+1)'(1);

    elapsed_n = elapsed_e;
    entry_nxt = entry_e;
    max_nxt   = max_e;
    miss_nxt  = miss_e;

    if (crossing) begin
      if (record) begin
        elapsed_n = '0;
        if (rec_first || hit) begin
          miss_nxt  = '0;
          entry_nxt = IDX_W'(1);
        end else if (({1'b0, idx} + (IDX_W+1)'(1)) > (IDX_W+1)'(DEPTH - 1)) begin
          entry_nxt = '0;
          max_nxt   = '0;
          miss_nxt  = '0;
        end else begin
          entry_nxt = idx + IDX_W'(1);
        end
      end else if (slope > max_e) begin
        // steeper edge: new reference, restart timing
        max_nxt   = slope;
        elapsed_n = '0;
        miss_nxt  = '0;
        entry_nxt = '0;
      end else if (miss_inc > {1'b0, mlim_r}) begin
        entry_nxt = '0;
        max_nxt   = '0;
        miss_nxt  = '0;
      end else begin
        miss_nxt = miss_inc[MISS_W-1:0];
      end
    end

    // first sample after clear only primes prev
    if (!pvalid_e) begin
      elapsed_nxt = elapsed_e;
    end else if (elapsed_n != TIME_MAX) begin
      elapsed_nxt = elapsed_n + TIME_W'(1);
    end else begin
      elapsed_nxt = elapsed_n;
    end
    prev_nxt = cur_r;
  end

  assign stat.hit  = hit;
  assign stat.more = idx > IDX_W'(1);
  assign stat.last = (k_r == (hit_idx_r - IDX_W'(1)));

  // stored intervals of entries 1 and up; entry 0 lives in time0_r
  smpd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.eval && record && (idx != '0)),
    .waddr (idx),
    .wdata (elapsed_e),
    .raddr (k_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r     <= smpd_pkg::MIDPOINT_RST;
      stol_r    <= smpd_pkg::SLOPE_TOL_RST;
      ttol_r    <= smpd_pkg::TIME_TOL_RST;
      mlim_r    <= smpd_pkg::MISS_LIMIT_RST;
      prev_r    <= '0;
      pvalid_r  <= 1'b0;
      elapsed_r <= '0;
      entry_r   <= '0;
      max_r     <= '0;
      miss_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          smpd_pkg::CFG_MIDPOINT:   mid_r  <= cfg_wdata[SAMPLE_W-1:0];
          smpd_pkg::CFG_SLOPE_TOL:  stol_r <= cfg_wdata[SLOPE_W-1:0];
          smpd_pkg::CFG_TIME_TOL:   ttol_r <= cfg_wdata[smpd_pkg::TTOL_W-1:0];
          smpd_pkg::CFG_MISS_LIMIT: mlim_r <= cfg_wdata[MISS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        prev_r    <= prev_nxt;
        pvalid_r  <= 1'b1;
        elapsed_r <= elapsed_nxt;
        entry_r   <= entry_nxt;
        max_r     <= max_nxt;
        miss_r    <= miss_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r <= in_sample;
      blk_r <= in_block_start;
    end
    if (cmd.eval && (rec_first || hit)) begin
      time0_r  <= elapsed_e;
      slope0_r <= slope;
    end
    if (cmd.eval) begin
      // sum starts from the old entry 0 before it is replaced
      acc_r     <= SUM_W'(time0_r);
      k_r       <= IDX_W'(1);
      hit_idx_r <= idx;
    end
    if (cmd.sum_add) begin
      acc_r <= acc_r + SUM_W'(ram_rdata);
      k_r   <= k_r + IDX_W'(1);
    end
    if (cmd.out_load) begin
      period_r <= (acc_r > SUM_W'(smpd_pkg::PERIOD_MAX)) ? smpd_pkg::PERIOD_MAX
                                                         : acc_r[PERIOD_W-1:0];
    end
  end

  assign out_period = period_r;

endmodule

// ===== rtl/core/slope_matching_period_detector.sv =====
// Slope-matching period detector. Takes one unsigned 8-bit audio sample per
// input beat and reports the waveform period in samples. An upward crossing
// of midpoint_level is a candidate event whose slope is the step across the
// crossing; crossings whose slope is near the running maximum are logged
// with the samples elapsed since the previous logged event, and when an
// event matches the first logged one in time and slope the logged intervals
// are summed and sent out as period (saturating at 2^20 - 1). A sample with
// block_start set clears the search state before it is used; configuration
// and the interval history survive it. An ordinary sample passes through the
// accept and evaluate states. A sample that closes a period also walks the
// interval RAM, with a read state and an add state per stored interval
// beyond the first because of the RAM's registered read, and then loads the
// result. The result register frees the input side, so only a second period
// result that finds the first still untaken waits on out_ready. Configuration
// writes take effect on the next clock and are meant for idle periods.
module slope_matching_period_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample beats
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smpd_pkg::SAMPLE_W-1:0]        in_sample,
  input  logic                                 in_block_start,
  // period beats
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [smpd_pkg::PERIOD_W-1:0]        out_period,
  // register writes
  input  logic                                 cfg_we,
  input  logic [smpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  smpd_pkg::smpd_cmd_t  cmd;
  smpd_pkg::smpd_stat_t stat;

  // sequencer: accept -> evaluate -> (read/add per interval) -> emit
  smpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // crossing logic, search state, interval history and accumulator
  smpd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_sample),
    .in_block_start (in_block_start),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_period     (out_period)
  );

endmodule

// ===== rtl/core/smpd_checker.sv =====
`include "slope_matching_period_detector_defines.svh"

module smpd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [smpd_pkg::PERIOD_W-1:0] out_period
);

  // a stalled result holds
  `SMPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_period), "result changed while stalled")

  // one sample at a time: busy right after an accept
  `SMPD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted back to back")

  // a new result is only loaded while the sequencer is busy
  `SMPD_ASSERT_NOW(a_result_from_work, $rose(out_valid), !$past(in_ready), "result appeared without work")

endmodule

bind slope_matching_period_detector smpd_checker u_smpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_period (out_period)
);
